@@ hw/rtl/fdot_pkg.sv @@
// fdot_pkg: shared types, constants and fp16/fp32 conversion functions
// for the fp16 linear row dot unit; no dependencies
package fdot_pkg;

   localparam int unsigned MAX_LENGTH_DEF = 1024;
   localparam int unsigned CMD_DEPTH_DEF  = 2;
   localparam int unsigned ROW_LEN_W      = 11;
   localparam int unsigned INDEX_W        = 10;

   // request command codes
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_WEIGHT = 2'd1;
   localparam logic [1:0] CMD_BIAS   = 2'd2;

   localparam int unsigned F32_EXP_BIAS = 127;
   localparam int unsigned F16_EXP_BIAS = 15;
   localparam int unsigned EXP_REBIAS   = F32_EXP_BIAS - F16_EXP_BIAS;
   localparam int unsigned MUL_EXP_OFS  = F32_EXP_BIAS - 2 * F16_EXP_BIAS;

   localparam logic [15:0] F16_SIGN  = 16'h8000;
   localparam logic [15:0] F16_INF   = 16'h7c00;
   localparam logic [15:0] F16_QNAN  = 16'h7e00;
   localparam logic [9:0]  F16_MAN   = 10'h3ff;
   localparam logic [4:0]  F16_EMAX  = 5'h1f;
   localparam logic [7:0]  F32_EMAX  = 8'hff;
   localparam logic [31:0] F32_QNAN  = 32'h7fc0_0000;

   typedef struct packed {
      logic [1:0]         command;
      logic [INDEX_W-1:0] element_index;
      logic [31:0]        input_element;
      logic [15:0]        weight;
      logic [15:0]        bias;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        extra_weights;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_WEIGHT = 2'd1,
      OP_BIAS   = 2'd2
   } op_type;

   // classified word between front and back
   typedef struct packed {
      op_type             op;
      logic [INDEX_W-1:0] index;
      logic [15:0]        half;
   } cmd_type;

   // fp32 to fp16 by truncation
   function automatic logic [15:0] narrow_half(input logic [31:0] b);
      logic [7:0] e8;
      logic [15:0] res;
      e8 = b[30:23];
      if (e8 == F32_EMAX && b[22:0] != 23'd0) begin
         res = F16_QNAN;
      end else if (e8 <= 8'(EXP_REBIAS)) begin
         res = {b[31], 15'd0};
      end else if (e8 >= 8'(EXP_REBIAS + 31)) begin
         res = {b[31], F16_INF[14:0]};
      end else begin
         res = {b[31], 5'(e8 - 8'(EXP_REBIAS)), b[22:13] & F16_MAN};
      end
      return res;
   endfunction

   // fp16 to fp32, subnormals flush to signed zero
   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [4:0] e5;
      logic [31:0] res;
      e5 = h[14:10];
      if (e5 == 5'd0) begin
         res = {h[15], 31'd0};
      end else if (e5 == F16_EMAX) begin
         res = {h[15], F32_EMAX, h[9:0], 13'd0};
      end else begin
         res = {h[15], 8'({3'd0, e5} + 8'(EXP_REBIAS)), h[9:0], 13'd0};
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/fdot_front.sv @@
// fdot_front: accepts request words, drops unused codes, narrows loads to fp16
// depends on fdot_pkg
module fdot_front import fdot_pkg::*; (
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    q_push,
   output cmd_type q_data,
   input  logic    q_full
);

   always_comb begin
      q_data.index = req_data.element_index;
      case (req_data.command)
         CMD_LOAD: begin
            q_data.op   = OP_LOAD;
            q_data.half = narrow_half(req_data.input_element);
         end
         CMD_WEIGHT: begin
            q_data.op   = OP_WEIGHT;
            q_data.half = req_data.weight;
         end
         default: begin
            q_data.op   = OP_BIAS;
            q_data.half = req_data.bias;
         end
      endcase
   end

   // unused command code is swallowed
   assign req_full = q_full;
   assign q_push   = req_push && !q_full &&
                     (req_data.command == CMD_LOAD || req_data.command == CMD_WEIGHT ||
                      req_data.command == CMD_BIAS);

endmodule

@@ hw/rtl/fdot_queue.sv @@
// fdot_queue: short command queue between front and back
// depends on fdot_pkg
module fdot_queue import fdot_pkg::*; #(
   parameter int unsigned DEPTH = CMD_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue push lost");

   a_ptrs_meet: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

@@ hw/rtl/fdot_back.sv @@
// fdot_back: input store, fp16 multiplier, fp32 rne adder sequencer, result queue
// depends on fdot_pkg
module fdot_back import fdot_pkg::*; #(
   parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ROW_LEN_W-1:0] row_length,
   input  logic                 cmd_empty,
   input  cmd_type              cmd,
   output logic                 cmd_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output rsp_type              rsp_data
);

   localparam int unsigned AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int unsigned POS_W = $clog2(MAX_LENGTH + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_ALIGN = 6'b000100,
      ST_ADD   = 6'b001000,
      ST_NORM  = 6'b010000,
      ST_ROUND = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              overrun_ff, overrun_in;
   logic [31:0]       acc_ff, acc_in;
   logic              is_bias_ff, is_bias_in;
   logic [15:0]       opnd_ff, opnd_in;
   logic [15:0]       store_ff [MAX_LENGTH];
   logic [15:0]       x_rd_ff;
   logic [31:0]       prod_ff;
   // align stage
   logic              spec_ff;
   logic [31:0]       spec_val_ff;
   logic              sign_ff, sub_ff;
   logic [7:0]        exp_ff;
   logic [26:0]       siga_ff, sigb_ff;
   // add and normalize stages
   logic [27:0]       sum_ff;
   logic [26:0]       nsig_ff;
   logic [9:0]        nexp_ff;
   logic              zero_ff;
   // result queue, two entries
   rsp_type           out_ff [2];
   logic              out_wr_ff, out_rd_ff;
   logic [1:0]        out_cnt_ff;

   logic [31:0]       eff_len, pos32, idx32;
   logic              mem_we, out_push, out_pop;
   logic [31:0]       prod_val, round_val;
   logic [4:0]        lz;

   assign pos32   = 32'(pos_ff);
   assign idx32   = 32'(cmd.index);
   assign eff_len = (32'(row_length) > MAX_LENGTH) ? 32'(MAX_LENGTH) : 32'(row_length);
   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty &&
                    (cmd.op != OP_BIAS || out_cnt_ff != 2'd2);
   assign mem_we  = cmd_pop && cmd.op == OP_LOAD && idx32 < MAX_LENGTH;

   // input store: one write port, one registered read at the row position,
   // captured when a word is taken so it holds for the whole operation
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[idx32[AW-1:0]] <= cmd.half;
      end
      if (cmd_pop) begin
         x_rd_ff <= store_ff[pos_ff[AW-1:0]];
      end
   end

   // exact fp16 x fp16 product in fp32, or the widened bias
   always_comb begin
      logic [4:0]  we, xe;
      logic        w_nan, x_nan, w_inf, x_inf, w_zero, x_zero, sgn;
      logic [21:0] p;
      logic [7:0]  e8;
      we     = opnd_ff[14:10];
      xe     = x_rd_ff[14:10];
      w_nan  = (we == F16_EMAX) && (opnd_ff[9:0] != 10'd0);
      x_nan  = (xe == F16_EMAX) && (x_rd_ff[9:0] != 10'd0);
      w_inf  = (we == F16_EMAX) && (opnd_ff[9:0] == 10'd0);
      x_inf  = (xe == F16_EMAX) && (x_rd_ff[9:0] == 10'd0);
      w_zero = (we == 5'd0);
      x_zero = (xe == 5'd0);
      sgn    = opnd_ff[15] ^ x_rd_ff[15];
      p      = 22'({1'b1, opnd_ff[9:0]}) * 22'({1'b1, x_rd_ff[9:0]});
      e8     = 8'({3'd0, we}) + 8'({3'd0, xe}) + 8'(MUL_EXP_OFS);
      if (is_bias_ff) begin
         prod_val = widen_half(opnd_ff);
      end else if (w_nan || x_nan) begin
         prod_val = F32_QNAN;
      end else if (w_inf || x_inf) begin
         prod_val = (w_zero || x_zero) ? F32_QNAN : {sgn, F32_EMAX, 23'd0};
      end else if (w_zero || x_zero) begin
         prod_val = {sgn, 31'd0};
      end else if (p[21]) begin
         prod_val = {sgn, e8 + 8'd1, p[20:0], 2'd0};
      end else begin
         prod_val = {sgn, e8, p[19:0], 3'd0};
      end
   end

   // leading zero count of the sum below the carry bit
   always_comb begin
      lz = '0;
      for (int i = 0; i < 27; i++) begin
         if (sum_ff[i]) begin
            lz = 5'(26 - i);
         end
      end
   end

   // round to nearest even and pack
   always_comb begin
      logic        up;
      logic [24:0] m;
      logic [9:0]  e;
      up = nsig_ff[2] && (nsig_ff[1] || nsig_ff[0] || nsig_ff[3]);
      m  = {1'b0, nsig_ff[26:3]} + 25'(up);
      e  = nexp_ff + 10'(m[24]);
      if (spec_ff) begin
         round_val = spec_val_ff;
      end else if (zero_ff) begin
         round_val = 32'd0;
      end else if (e[9] || e == 10'd0) begin
         round_val = {sign_ff, 31'd0};
      end else if (e >= 10'd255) begin
         round_val = {sign_ff, F32_EMAX, 23'd0};
      end else begin
         round_val = {sign_ff, e[7:0], m[24] ? 23'd0 : m[22:0]};
      end
   end

   assign out_push = (state_ff == ST_ROUND) && is_bias_ff;
   assign out_pop  = rsp_pop && !rsp_empty;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      overrun_in = overrun_ff;
      acc_in     = acc_ff;
      is_bias_in = is_bias_ff;
      opnd_in    = opnd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               case (cmd.op)
                  OP_WEIGHT: begin
                     if (pos32 < eff_len) begin
                        state_in   = ST_MUL;
                        pos_in     = pos_ff + 1'b1;
                        is_bias_in = 1'b0;
                        opnd_in    = cmd.half;
                     end else begin
                        overrun_in = 1'b1;
                     end
                  end
                  OP_BIAS: begin
                     state_in   = ST_MUL;
                     is_bias_in = 1'b1;
                     opnd_in    = cmd.half;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL:   state_in = ST_ALIGN;
         ST_ALIGN: state_in = ST_ADD;
         ST_ADD:   state_in = ST_NORM;
         ST_NORM:  state_in = ST_ROUND;
         ST_ROUND: begin
            state_in = ST_IDLE;
            if (is_bias_ff) begin
               acc_in     = 32'd0;
               pos_in     = '0;
               overrun_in = 1'b0;
            end else begin
               acc_in = round_val;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         overrun_ff <= 1'b0;
         acc_ff     <= 32'd0;
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         overrun_ff <= overrun_in;
         acc_ff     <= acc_in;
         if (out_push) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= ~out_rd_ff;
         end
         if (out_push && !out_pop) begin
            out_cnt_ff <= out_cnt_ff + 2'd1;
         end else if (out_pop && !out_push) begin
            out_cnt_ff <= out_cnt_ff - 2'd1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
      logic [31:0] big, sml;
      logic [7:0]  d;
      logic [26:0] sigs, shifted, mask;
      logic        sticky;
      logic        spec;
      logic [31:0] spec_val;
      is_bias_ff <= is_bias_in;
      opnd_ff    <= opnd_in;
      prod_ff    <= prod_val;
      // align: specials, order by magnitude, shift the smaller operand
      sa     = acc_ff[31];
      sb     = prod_ff[31];
      a_nan  = (acc_ff[30:23] == F32_EMAX) && (acc_ff[22:0] != 23'd0);
      b_nan  = (prod_ff[30:23] == F32_EMAX) && (prod_ff[22:0] != 23'd0);
      a_inf  = (acc_ff[30:23] == F32_EMAX) && (acc_ff[22:0] == 23'd0);
      b_inf  = (prod_ff[30:23] == F32_EMAX) && (prod_ff[22:0] == 23'd0);
      a_zero = (acc_ff[30:23] == 8'd0);
      b_zero = (prod_ff[30:23] == 8'd0);
      swap   = prod_ff[30:0] > acc_ff[30:0];
      big    = swap ? prod_ff : acc_ff;
      sml    = swap ? acc_ff : prod_ff;
      d      = big[30:23] - sml[30:23];
      sigs   = {1'b1, sml[22:0], 3'd0};
      if (d >= 8'd27) begin
         shifted = '0;
         sticky  = 1'b1;
      end else begin
         mask    = (27'd1 << d) - 27'd1;
         shifted = sigs >> d;
         sticky  = |(sigs & mask);
      end
      spec = 1'b1;
      if (a_nan || b_nan) begin
         spec_val = F32_QNAN;
      end else if (a_inf && b_inf) begin
         spec_val = (sa != sb) ? F32_QNAN : acc_ff;
      end else if (a_inf) begin
         spec_val = acc_ff;
      end else if (b_inf) begin
         spec_val = prod_ff;
      end else if (a_zero && b_zero) begin
         spec_val = {sa && sb, 31'd0};
      end else if (a_zero) begin
         spec_val = prod_ff;
      end else if (b_zero) begin
         spec_val = acc_ff;
      end else begin
         spec     = 1'b0;
         spec_val = acc_ff;
      end
      spec_ff     <= spec;
      spec_val_ff <= spec_val;
      sign_ff <= big[31];
      sub_ff  <= sa ^ sb;
      exp_ff  <= big[30:23];
      siga_ff <= {1'b1, big[22:0], 3'd0};
      sigb_ff <= {shifted[26:1], shifted[0] | sticky};
      // add
      sum_ff  <= sub_ff ? ({1'b0, siga_ff} - {1'b0, sigb_ff})
                        : ({1'b0, siga_ff} + {1'b0, sigb_ff});
      // normalize
      zero_ff <= (sum_ff == 28'd0);
      if (sum_ff[27]) begin
         nsig_ff <= {sum_ff[27:2], sum_ff[1] | sum_ff[0]};
         nexp_ff <= {2'd0, exp_ff} + 10'd1;
      end else begin
         nsig_ff <= sum_ff[26:0] << lz;
         nexp_ff <= {2'd0, exp_ff} - {5'd0, lz};
      end
      if (out_push) begin
         out_ff[out_wr_ff] <= '{result_value:  widen_half(narrow_half(round_val)),
                               extra_weights: overrun_ff};
      end
   end

   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp_data  = out_ff[out_rd_ff];

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= 2'd2)
      else $error("result queue overflow");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos32 <= eff_len || $past(pos32) == pos32)
      else $error("row position beyond row length");

   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && is_bias_ff) |=>
         (acc_ff == 32'd0 && pos_ff == '0 && !overrun_ff))
      else $error("row state not cleared after bias");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == ST_IDLE || state_ff == ST_MUL))
      else $error("command taken while busy");

endmodule

@@ hw/rtl/fp16_linear_row_dot_unit.sv @@
// fp16_linear_row_dot_unit: top level of the fp16 matrix-vector row engine
// depends on fdot_pkg, fdot_front, fdot_queue, fdot_back
//
//   channel  | ports                                  | direction
//   ---------+----------------------------------------+----------
//   request  | req_push, req_data, req_full           | in
//   response | rsp_pop, rsp_data, rsp_empty           | out
//   csr      | csr_write_enable, csr_write_data       | in
//
// a load word is taken by the back end while it stays idle; a weight or bias word
// passes through pop, multiply, align, add, normalize and round in turn, on the
// serial fp32 accumulate loop through the shared adder
// reset is synchronous and clears control state; the input store is not cleared
// the command queue lets requests arrive while the back end is busy, and a
// two-word result queue keeps the back end running while rsp_pop is low
module fp16_linear_row_dot_unit import fdot_pkg::*; #(
   parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF,
   parameter int unsigned CMD_DEPTH  = CMD_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  req_type              req_data,
   output logic                 req_full,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   output logic                 rsp_empty,
   input  logic                 csr_write_enable,
   input  logic [ROW_LEN_W-1:0] csr_write_data
);

   // row length register, reset to one element per row
   logic [ROW_LEN_W-1:0] row_length_ff;

   // front to queue
   logic    q_push, q_full;
   cmd_type q_in;
   // queue to back
   logic    q_pop, q_empty;
   cmd_type q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LEN_W'(1);
      end else if (csr_write_enable) begin
         row_length_ff <= csr_write_data;
      end
   end

   // classify and narrow incoming words
   fdot_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (q_push),
      .q_data   (q_in),
      .q_full   (q_full)
   );

   // decouples request side from the arithmetic sequencer
   fdot_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // store, multiply-accumulate and result queue
   fdot_back #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .row_length (row_length_ff),
      .cmd_empty  (q_empty),
      .cmd        (q_out),
      .cmd_pop    (q_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/fdot_checker.sv @@
// fdot_checker: watches the request, response and csr channels of the fp16 row dot unit,
// predicts every row result and compares it; depends on fdot_pkg
`timescale 1ns / 100ps

module fdot_checker import fdot_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  req_type              req_data,
   input  logic                 req_full,
   input  logic                 rsp_pop,
   input  rsp_type              rsp_data,
   input  logic                 rsp_empty,
   input  logic                 csr_write_enable,
   input  logic [ROW_LEN_W-1:0] csr_write_data,
   output int                   failures,
   output int                   pending,
   output int                   checked
);

   localparam logic [31:0] NAN32 = 32'h7fc0_0000;

   logic [15:0]          half_store [MAX_LENGTH_DEF];
   logic [31:0]          row_acc;
   int unsigned          row_pos;
   logic                 row_overrun;
   logic [ROW_LEN_W-1:0] row_len;
   rsp_type              row_results [$];

   function automatic bit is_nan32(input logic [31:0] a);
      return a[30:23] == 8'hff && a[22:0] != 23'd0;
   endfunction

   // fp32 to fp16, mantissa cut without rounding
   function automatic logic [15:0] cut_to_half(input logic [31:0] a);
      int e;
      e = a[30:23];
      if (is_nan32(a)) return 16'h7e00;
      if (e <= 112) return {a[31], 15'd0};
      if (e >= 143) return {a[31], 5'h1f, 10'd0};
      return {a[31], 5'(e - 112), a[22:13]};
   endfunction

   // fp16 to fp32, subnormals flushed
   function automatic logic [31:0] grow_to_single(input logic [15:0] h);
      if (h[14:10] == 5'd0) return {h[15], 31'd0};
      if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
      return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
   endfunction

   // exact product of two fp16 values as fp32
   function automatic logic [31:0] half_product(input logic [15:0] w, input logic [15:0] x);
      logic        s;
      logic [21:0] p;
      int          e;
      s = w[15] ^ x[15];
      if ((w[14:10] == 5'h1f && w[9:0] != 0) || (x[14:10] == 5'h1f && x[9:0] != 0))
         return NAN32;
      if (w[14:10] == 5'h1f || x[14:10] == 5'h1f) begin
         if (w[14:10] == 5'd0 || x[14:10] == 5'd0) return NAN32;
         return {s, 8'hff, 23'd0};
      end
      if (w[14:10] == 5'd0 || x[14:10] == 5'd0) return {s, 31'd0};
      p = {1'b1, w[9:0]} * {1'b1, x[9:0]};
      e = w[14:10] + x[14:10];
      if (p[21]) return {s, 8'(e + 98), p[20:0], 2'd0};
      return {s, 8'(e + 97), p[19:0], 3'd0};
   endfunction

   // fp32 add, round to nearest even, done on an exact wide fixed point
   function automatic logic [31:0] single_sum(input logic [31:0] a, input logic [31:0] b);
      logic [299:0] ma, mb, mag;
      logic [24:0]  keep;
      logic         sr, g, st;
      int           ea, eb, p, lsb, er;
      ea = a[30:23];
      eb = b[30:23];
      if (is_nan32(a) || is_nan32(b)) return NAN32;
      if (ea == 255 && eb == 255) return (a[31] != b[31]) ? NAN32 : a;
      if (ea == 255) return a;
      if (eb == 255) return b;
      ma = 300'({ea != 0, a[22:0]}) << ((ea == 0) ? 0 : ea - 1);
      mb = 300'({eb != 0, b[22:0]}) << ((eb == 0) ? 0 : eb - 1);
      if (a[31] == b[31]) begin
         mag = ma + mb;
         sr = a[31];
      end else if (ma >= mb) begin
         mag = ma - mb;
         sr = a[31];
      end else begin
         mag = mb - ma;
         sr = b[31];
      end
      if (mag == 0) return {a[31] & b[31], 31'd0};
      p = 0;
      for (int i = 299; i >= 0; i--) begin
         if (mag[i]) begin
            p = i;
            break;
         end
      end
      if (p < 23) return {sr, 8'd0, mag[22:0]};
      lsb = p - 23;
      keep = 25'(mag >> lsb);
      g = (lsb > 0) ? mag[lsb-1] : 1'b0;
      st = (lsb > 1) ? ((mag & ((300'd1 << (lsb - 1)) - 300'd1)) != 0) : 1'b0;
      er = p - 22;
      if (g && (st || keep[0])) keep = keep + 25'd1;
      if (keep[24]) begin
         keep = keep >> 1;
         er++;
      end
      if (er >= 255) return {sr, 8'hff, 23'd0};
      return {sr, 8'(er), keep[22:0]};
   endfunction

   // apply one accepted request word to the predicted state
   task automatic predict_word(input req_type d);
      int unsigned eff;
      rsp_type     r;
      eff = (row_len > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : row_len;
      case (d.command)
         CMD_LOAD: half_store[d.element_index] = cut_to_half(d.input_element);
         CMD_WEIGHT: begin
            if (row_pos < eff) begin
               row_acc = single_sum(row_acc, half_product(d.weight, half_store[row_pos]));
               row_pos++;
            end else begin
               row_overrun = 1'b1;
            end
         end
         CMD_BIAS: begin
            r.result_value = grow_to_single(cut_to_half(
               single_sum(row_acc, grow_to_single(d.bias))));
            r.extra_weights = row_overrun;
            row_results.push_back(r);
            row_acc = 32'd0;
            row_pos = 0;
            row_overrun = 1'b0;
         end
         default: ;
      endcase
   endtask

   assign pending = row_results.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         row_acc = 32'd0;
         row_pos = 0;
         row_overrun = 1'b0;
         row_len = ROW_LEN_W'(1);
         row_results.delete();
         failures = 0;
         checked = 0;
      end else begin
         if (csr_write_enable) row_len = csr_write_data;
         if (req_push && !req_full) predict_word(req_data);
         if (rsp_pop && !rsp_empty) begin
            if (row_results.size() == 0) begin
               $error("unexpected result word %h", rsp_data);
               failures++;
            end else begin
               want = row_results.pop_front();
               checked++;
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value expected %h actual %h",
                         want.result_value, rsp_data.result_value);
                  failures++;
               end
               if (rsp_data.extra_weights !== want.extra_weights) begin
                  $error("extra_weights expected %b actual %b",
                         want.extra_weights, rsp_data.extra_weights);
                  failures++;
               end
            end
         end
      end
   end

endmodule

@@ tb/tb.sv @@
// tb: stimulus and verdict for fp16_linear_row_dot_unit
// depends on fdot_pkg, the unit's rtl and fdot_checker
`timescale 1ns / 100ps

module tb import fdot_pkg::*;;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   req_type              req_data;
   logic                 req_full;
   logic                 rsp_pop;
   rsp_type              rsp_data;
   logic                 rsp_empty;
   logic                 csr_write_enable;
   logic [ROW_LEN_W-1:0] csr_write_data;
   int                   failures, pending, checked;

   // stimulus side view of the unit, only what keeps weights on written entries
   bit          loaded [MAX_LENGTH_DEF];
   int unsigned next_pos;
   int unsigned eff_len;
   int          words_sent;
   int          settings_used;
   bit          calm;

   fp16_linear_row_dot_unit dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_data(rsp_data), .rsp_empty(rsp_empty),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   fdot_checker chk (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_data(rsp_data), .rsp_empty(rsp_empty),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .failures(failures), .pending(pending), .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #3_000_000;
      $display("FAIL fp16_linear_row_dot_unit");
      $finish;
   end

   // consumer holds rsp_pop low with a chance of 17 in a hundred, never while calm
   always @(posedge clock) begin
      rsp_pop <= calm || ($urandom_range(0, 99) >= 17);
   end

   // mostly moderate fp32 values, sometimes any bit pattern
   function automatic logic [31:0] pick_element();
      if ($urandom_range(0, 9) < 8)
         return {1'($urandom), 8'($urandom_range(105, 145)), 23'($urandom)};
      return $urandom;
   endfunction

   function automatic logic [15:0] pick_half();
      if ($urandom_range(0, 9) < 8)
         return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
      return 16'($urandom);
   endfunction

   // one word on the request queue; called right after a rising edge
   task automatic push_word(input logic [1:0] cmd, input logic [INDEX_W-1:0] idx,
                            input logic [31:0] elem, input logic [15:0] w,
                            input logic [15:0] b);
      req_type d;
      d = {cmd, idx, elem, w, b};
      if (!calm && $urandom_range(0, 99) < 17) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= d;
      @(negedge clock);
      while (req_full) @(negedge clock);
      @(posedge clock);
      words_sent++;
      case (cmd)
         CMD_LOAD: loaded[idx] = 1'b1;
         CMD_WEIGHT: if (next_pos < eff_len) next_pos++;
         CMD_BIAS: next_pos = 0;
         default: ;
      endcase
   endtask

   task automatic load_word(input int idx, input logic [31:0] elem);
      push_word(CMD_LOAD, INDEX_W'(idx), elem, 16'($urandom), 16'($urandom));
   endtask

   // weight word, loading its paired entry first if never written
   task automatic weight_word(input logic [15:0] w);
      if (next_pos < eff_len && !loaded[next_pos]) load_word(next_pos, pick_element());
      push_word(CMD_WEIGHT, INDEX_W'($urandom), $urandom, w, 16'($urandom));
   endtask

   task automatic bias_word(input logic [15:0] b);
      push_word(CMD_BIAS, INDEX_W'($urandom), $urandom, 16'($urandom), b);
   endtask

   // wait out every expected row and the back end's tail before touching csr
   task automatic drain();
      req_push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_row_length(input int len);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= ROW_LEN_W'(len);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      eff_len = (len > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : len;
      settings_used++;
   endtask

   // one row: full, short or overrun, with loads and noise mixed in
   task automatic random_row(input int force_count);
      int n, kind;
      kind = $urandom_range(0, 9);
      if (force_count >= 0) n = force_count;
      else if (eff_len == 0) n = $urandom_range(0, 3);
      else if (kind == 0) n = $urandom_range(0, eff_len - 1);
      else if (kind == 1) n = eff_len + $urandom_range(1, 3);
      else n = eff_len;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) load_word($urandom_range(0, MAX_LENGTH_DEF - 1),
                                                   pick_element());
         if ($urandom_range(0, 29) == 0)
            push_word(CMD_UNUSED, INDEX_W'($urandom), $urandom, 16'($urandom),
                      16'($urandom));
         weight_word(pick_half());
      end
      bias_word(pick_half());
   endtask

   initial begin
      int lens [9];
      lens = '{1, 2, 3, 5, 8, 16, 0, 2047, 1024};
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      calm = 1'b0;
      words_sent = 0;
      settings_used = 0;
      next_pos = 0;
      eff_len = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default length of one, plain row
      load_word(0, 32'h3f80_0000);
      weight_word(16'h3c00);
      bias_word(16'h0000);
      // largest fp16 squared overflows, subnormal weight flushes, one weight too many
      set_row_length(3);
      load_word(0, 32'h477f_e000);
      load_word(1, 32'h3300_0000);
      load_word(2, 32'h3f80_0001);
      weight_word(16'h7bff);
      weight_word(16'h0001);
      weight_word(16'h3c00);
      weight_word(16'h3c00);
      bias_word(16'h8000);
      // infinity, fp16 overflow to -inf, nan, then a short row
      load_word(0, 32'h7f80_0000);
      load_word(1, 32'hc780_0000);
      load_word(2, 32'hff80_0001);
      weight_word(16'h3c00);
      bias_word(16'hfc00);
      push_word(CMD_UNUSED, '1, '1, '1, '1);
      load_word(MAX_LENGTH_DEF - 1, 32'h3880_0000);
      weight_word(16'h7e01);
      weight_word(16'hffff);
      bias_word(16'h7c00);

      // random phases over several row lengths; the long lengths get one short row each
      for (int k = 0; k < 9; k++) begin
         set_row_length(lens[k]);
         if (lens[k] >= MAX_LENGTH_DEF) begin
            random_row(4);
         end else begin
            calm = (k == 3);
            while (words_sent < 150 * (k + 1)) random_row(-1);
            calm = 1'b0;
         end
      end
      set_row_length(4);
      while (words_sent < 1400) random_row(-1);

      drain();
      $display("sent %0d request words across %0d row length settings", words_sent,
               settings_used);
      $display("checked %0d row results, %0d failures", checked, failures);
      if (failures == 0) begin
         $display("PASS fp16_linear_row_dot_unit");
      end else begin
         $display("FAIL fp16_linear_row_dot_unit");
      end
      $finish;
   end

endmodule
